### src/jtsl_pkg.sv
package jtsl_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_LBRACE   = 8'h7b;
  localparam logic [7:0] CH_RBRACE   = 8'h7d;
  localparam logic [7:0] CH_COLON    = 8'h3a;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6e;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0a;

  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_KEY      = 4'd4;
  localparam logic [3:0] KIND_STRING   = 4'd5;
  localparam logic [3:0] KIND_NUMBER   = 4'd8;

  localparam logic [1:0] CLASS_STRING = 2'd0;
  localparam logic [1:0] CLASS_BOOL   = 2'd1;
  localparam logic [1:0] CLASS_NULL   = 2'd2;
  localparam logic [1:0] CLASS_NUMBER = 2'd3;

  typedef struct packed {
    logic [3:0] kind;
    logic       has_char;
    logic [7:0] ch;
    logic       done;
    logic       last;
  } res_t;

  // all results caused by one byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic res_t mk_res(logic [3:0] kind, logic has, logic [7:0] ch, logic done);
    res_t r;
    r.kind     = kind;
    r.has_char = has;
    r.ch       = has ? ch : 8'h00;
    r.done     = done;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

### src/jtsl_front.sv
module jtsl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             new_document_i,
  input  jtsl_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output jtsl_pkg::rec_t   rec_o
);
  import jtsl_pkg::*;

  logic       oq_q, oq_d;
  logic       ia_q, ia_d;
  logic       wk_q, wk_d;
  logic       wv_q, wv_d;
  logic       kos_q, kos_d;
  logic       vb_q, vb_d;
  logic [1:0] cls_q, cls_d;

  logic [7:0] c;
  logic       keep;
  logic       do_idle;
  logic [1:0] cnt;
  res_t       r0, r1, rx;
  logic       accept;

  assign c          = in_byte_i;
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    oq_d  = oq_q;
    ia_d  = ia_q;
    wk_d  = wk_q;
    wv_d  = wv_q;
    kos_d = kos_q;
    vb_d  = vb_q;
    cls_d = cls_q;
    if (new_document_i) begin
      oq_d  = 1'b0;
      ia_d  = 1'b0;
      wk_d  = 1'b0;
      wv_d  = 1'b0;
      kos_d = 1'b0;
      vb_d  = 1'b0;
      cls_d = CLASS_STRING;
    end
    cnt     = 2'd0;
    do_idle = 1'b0;
    r0      = '0;
    r1      = '0;
    rx      = '0;

    keep = !(c inside {CH_SPACE, CH_LF, CH_TAB}) || oq_d;
    if (c == CH_QUOTE) oq_d = !oq_d;

    if (keep) begin
      if (wk_d) begin
        if (c == CH_LBRACE || (c == CH_RBRACE && !kos_d)) begin
          wk_d    = 1'b0;
          do_idle = 1'b1;
        end else if (c != CH_QUOTE) begin
          r0  = mk_res(KIND_KEY, 1'b1, c, 1'b0);
          cnt = 2'd1;
        end else if (kos_d) begin
          wk_d  = 1'b0;
          kos_d = 1'b0;
          r0    = mk_res(KIND_KEY, 1'b0, c, 1'b1);
          cnt   = 2'd1;
        end else begin
          kos_d = 1'b1;
        end
      end else if (wv_d) begin
        if (!vb_d) begin
          if (c inside {CH_LBRACKET, CH_LBRACE, CH_RBRACKET}) begin
            wv_d    = 1'b0;
            do_idle = 1'b1;
          end else begin
            vb_d = 1'b1;
            if (c == CH_QUOTE) begin
              cls_d = CLASS_STRING;
            end else begin
              if (c == CH_T || c == CH_F) cls_d = CLASS_BOOL;
              else if (c == CH_N)         cls_d = CLASS_NULL;
              else                        cls_d = CLASS_NUMBER;
              r0  = mk_res(KIND_STRING + {2'b00, cls_d}, 1'b1, c, 1'b0);
              cnt = 2'd1;
            end
          end
        end else if (cls_d == CLASS_STRING) begin
          if (c == CH_QUOTE) begin
            r0    = mk_res(KIND_STRING, 1'b0, c, 1'b1);
            cnt   = 2'd1;
            wv_d  = 1'b0;
            vb_d  = 1'b0;
          end else begin
            r0  = mk_res(KIND_STRING, 1'b1, c, 1'b0);
            cnt = 2'd1;
          end
        end else if (c inside {CH_COMMA, CH_RBRACKET, CH_RBRACE}) begin
          // bare value closes, then the delimiter acts on its own
          r0    = mk_res(KIND_STRING + {2'b00, cls_d}, 1'b0, c, 1'b1);
          cnt   = 2'd1;
          wv_d  = 1'b0;
          vb_d  = 1'b0;
          cls_d = CLASS_STRING;
          if (c == CH_COMMA) begin
            if (ia_d) wv_d = 1'b1;
            else      wk_d = 1'b1;
          end else begin
            do_idle = 1'b1;
          end
        end else begin
          r0  = mk_res(KIND_STRING + {2'b00, cls_d}, 1'b1, c, 1'b0);
          cnt = 2'd1;
        end
      end else begin
        do_idle = 1'b1;
      end

      if (do_idle) begin
        case (c)
          CH_LBRACE: begin
            rx   = mk_res(KIND_LBRACE, 1'b1, c, 1'b1);
            wk_d = 1'b1;
            wv_d = 1'b0;
            ia_d = 1'b0;
          end
          CH_RBRACE: begin
            rx = mk_res(KIND_RBRACE, 1'b1, c, 1'b1);
          end
          CH_LBRACKET: begin
            rx   = mk_res(KIND_LBRACKET, 1'b1, c, 1'b1);
            wk_d = 1'b0;
            ia_d = 1'b1;
            wv_d = 1'b1;
          end
          CH_RBRACKET: begin
            rx   = mk_res(KIND_RBRACKET, 1'b1, c, 1'b1);
            ia_d = 1'b0;
          end
          CH_COLON: begin
            wk_d = 1'b0;
            wv_d = 1'b1;
          end
          CH_COMMA: begin
            wk_d = !ia_d;
            wv_d = ia_d;
          end
          default: ;
        endcase
        if (c inside {CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET}) begin
          if (cnt == 2'd0) begin
            r0  = rx;
            cnt = 2'd1;
          end else begin
            r1  = rx;
            cnt = 2'd2;
          end
        end
      end
    end

    r0.last = (cnt == 2'd1);
    r1.last = 1'b1;
  end

  assign push_o     = accept && (cnt != 2'd0);
  assign rec_o.two  = (cnt == 2'd2);
  assign rec_o.r0   = r0;
  assign rec_o.r1   = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_q  <= 1'b0;
      ia_q  <= 1'b0;
      wk_q  <= 1'b0;
      wv_q  <= 1'b0;
      kos_q <= 1'b0;
      vb_q  <= 1'b0;
      cls_q <= CLASS_STRING;
    end else if (accept) begin
      oq_q  <= oq_d;
      ia_q  <= ia_d;
      wk_q  <= wk_d;
      wv_q  <= wv_d;
      kos_q <= kos_d;
      vb_q  <= vb_d;
      cls_q <= cls_d;
    end
  end

endmodule

### src/jtsl_queue.sv
module jtsl_queue #(
  parameter int unsigned Depth = jtsl_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jtsl_pkg::rec_t    wdata_i,
  input  logic              pop_i,
  output jtsl_pkg::rec_t    rdata_o,
  output jtsl_pkg::q_stat_t stat_o
);
  import jtsl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### src/jtsl_back.sv
module jtsl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jtsl_pkg::rec_t    rec_i,
  input  jtsl_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jtsl_pkg::res_t    res_o
);
  import jtsl_pkg::*;

  logic out_valid_q;
  res_t res_q;
  logic sec_v_q;
  res_t sec_q;
  logic load;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = load && !sec_v_q && !q_stat_i.empty;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_v_q     <= 1'b0;
    end else if (load) begin
      if (sec_v_q) begin
        out_valid_q <= 1'b1;
        sec_v_q     <= 1'b0;
      end else if (!q_stat_i.empty) begin
        out_valid_q <= 1'b1;
        sec_v_q     <= rec_i.two;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_v_q) begin
        res_q <= sec_q;
      end else if (!q_stat_i.empty) begin
        res_q <= rec_i.r0;
        sec_q <= rec_i.r1;
      end
    end
  end

endmodule

### src/json_token_stream_lexer_unit.sv
// Byte-stream JSON tokenizer: one input byte per cycle while the record queue is not full,
// 0 to 2 tokens out per byte. The first result of a byte is written as a record to the
// queue, then loaded into the output register, which out_ready_i can hold.
// A byte with two results occupies the output for both of them in turn, and the record
// queue (QueueDepth entries) absorbs those bursts.
// Reset (rst_ni low, asynchronous) clears all lexer flags, the queue and the output stage.
module json_token_stream_lexer_unit #(
  parameter int unsigned QueueDepth = jtsl_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       new_document_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_kind_o,
  output logic       has_char_o,
  output logic [7:0] out_char_o,
  output logic       token_done_o,
  output logic       last_of_run_o
);
  import jtsl_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  rec_t    wrec, rrec;
  res_t    res;

  jtsl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .new_document_i (new_document_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .rec_o          (wrec)
  );

  jtsl_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wrec),
    .pop_i   (pop),
    .rdata_o (rrec),
    .stat_o  (q_stat)
  );

  jtsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rrec),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign token_kind_o  = res.kind;
  assign has_char_o    = res.has_char;
  assign out_char_o    = res.ch;
  assign token_done_o  = res.done;
  assign last_of_run_o = res.last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full || pop) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("queue underflow");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o) |=> out_valid_o)
    else $error("second result of a byte not delivered next");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_char_o) |-> (out_char_o == 8'h00))
    else $error("char set without has_char");

endmodule
